// ----- hw/rtl/pntg_pkg.sv -----
package pntg_pkg;

    localparam int WAVE_POINTS = 64;
    localparam int WAVE_IDX_W  = $clog2(WAVE_POINTS);
    localparam int SINE_DEPTH  = 64;
    localparam int SINE_POS_W  = $clog2(SINE_DEPTH);

    localparam logic [7:0]  CMP_RESET    = 8'd35;
    localparam logic [7:0]  PERIOD_RESET = 8'd141;
    localparam logic [4:0]  NOTE_MAX     = 5'd24;
    localparam logic [2:0]  VOL_MAX      = 3'd7;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_PITCH  = 2'd1,
        MODE_VOLUME = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NOTE   = 2'd0,
        KIND_VOLUME = 2'd1,
        KIND_SAMPLE = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] reading;
        logic        play_enable;
    } item_t;

    typedef struct packed {
        logic [4:0] note;
        logic [7:0] period;
        logic [2:0] volume;
    } bands_t;

    function automatic logic [7:0] note_period(input logic [4:0] n);
        logic [7:0] p;
        case (n)
            5'd0:    p = 8'd239;
            5'd1:    p = 8'd225;
            5'd2:    p = 8'd213;
            5'd3:    p = 8'd201;
            5'd4:    p = 8'd190;
            5'd5:    p = 8'd179;
            5'd6:    p = 8'd169;
            5'd7:    p = 8'd159;
            5'd8:    p = 8'd150;
            5'd9:    p = 8'd142;
            5'd10:   p = 8'd134;
            5'd11:   p = 8'd126;
            5'd12:   p = 8'd119;
            5'd13:   p = 8'd113;
            5'd14:   p = 8'd106;
            5'd15:   p = 8'd100;
            5'd16:   p = 8'd95;
            5'd17:   p = 8'd89;
            5'd18:   p = 8'd84;
            5'd19:   p = 8'd80;
            5'd20:   p = 8'd75;
            5'd21:   p = 8'd71;
            5'd22:   p = 8'd67;
            5'd23:   p = 8'd63;
            default: p = 8'd60;
        endcase
        return p;
    endfunction

    function automatic logic [11:0] sine_value(input logic [SINE_POS_W-1:0] i);
        logic [11:0] s;
        case (i)
            6'd0:    s = 12'd2048;
            6'd1:    s = 12'd2249;
            6'd2:    s = 12'd2447;
            6'd3:    s = 12'd2642;
            6'd4:    s = 12'd2831;
            6'd5:    s = 12'd3013;
            6'd6:    s = 12'd3185;
            6'd7:    s = 12'd3347;
            6'd8:    s = 12'd3495;
            6'd9:    s = 12'd3630;
            6'd10:   s = 12'd3750;
            6'd11:   s = 12'd3853;
            6'd12:   s = 12'd3939;
            6'd13:   s = 12'd4007;
            6'd14:   s = 12'd4056;
            6'd15:   s = 12'd4085;
            6'd16:   s = 12'd4095;
            6'd17:   s = 12'd4085;
            6'd18:   s = 12'd4056;
            6'd19:   s = 12'd4007;
            6'd20:   s = 12'd3939;
            6'd21:   s = 12'd3853;
            6'd22:   s = 12'd3750;
            6'd23:   s = 12'd3630;
            6'd24:   s = 12'd3495;
            6'd25:   s = 12'd3347;
            6'd26:   s = 12'd3185;
            6'd27:   s = 12'd3013;
            6'd28:   s = 12'd2831;
            6'd29:   s = 12'd2642;
            6'd30:   s = 12'd2447;
            6'd31:   s = 12'd2249;
            6'd32:   s = 12'd2048;
            6'd33:   s = 12'd1847;
            6'd34:   s = 12'd1649;
            6'd35:   s = 12'd1454;
            6'd36:   s = 12'd1265;
            6'd37:   s = 12'd1083;
            6'd38:   s = 12'd911;
            6'd39:   s = 12'd749;
            6'd40:   s = 12'd601;
            6'd41:   s = 12'd466;
            6'd42:   s = 12'd346;
            6'd43:   s = 12'd243;
            6'd44:   s = 12'd157;
            6'd45:   s = 12'd89;
            6'd46:   s = 12'd40;
            6'd47:   s = 12'd11;
            6'd48:   s = 12'd1;
            6'd49:   s = 12'd11;
            6'd50:   s = 12'd40;
            6'd51:   s = 12'd89;
            6'd52:   s = 12'd157;
            6'd53:   s = 12'd243;
            6'd54:   s = 12'd346;
            6'd55:   s = 12'd466;
            6'd56:   s = 12'd601;
            6'd57:   s = 12'd749;
            6'd58:   s = 12'd911;
            6'd59:   s = 12'd1083;
            6'd60:   s = 12'd1265;
            6'd61:   s = 12'd1454;
            6'd62:   s = 12'd1649;
            default: s = 12'd1847;
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/pntg_bands.sv -----
module pntg_bands
    import pntg_pkg::*;
(
    input  logic [15:0] reading,
    output bands_t      bands
);

    logic        lt_75;
    logic        ge_225;
    logic        ge_450;
    logic        ge_650;
    logic [9:0]  offset;
    logic [20:0] product;
    logic [4:0]  quotient;

    assign lt_75  = reading < 16'd75;
    assign ge_225 = reading >= 16'd225;
    assign ge_450 = reading >= 16'd450;
    assign ge_650 = reading >= 16'd650;

    // divide by 25 through a reciprocal, exact for offsets below 575
    assign offset   = reading[9:0] - 10'd75;
    assign product  = {11'd0, offset} * 21'd1311;
    assign quotient = product[19:15];

    always_comb
    begin
        if (lt_75)
        begin
            bands.note = 5'd0;
        end
        else if (ge_650)
        begin
            bands.note = NOTE_MAX;
        end
        else
        begin
            bands.note = quotient + 5'd1;
        end

        if (lt_75 || ge_450)
        begin
            bands.volume = 3'd0;
        end
        else if (ge_225)
        begin
            bands.volume = VOL_MAX;
        end
        else
        begin
            bands.volume = quotient[2:0] + 3'd1;
        end

        bands.period = note_period(bands.note);
    end

endmodule

// ----- hw/rtl/pntg_engine.sv -----
module pntg_engine
    import pntg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        out_ready,
    output logic        advance,
    output logic        out_valid,
    output logic [1:0]  out_kind,
    output logic [11:0] out_value
);

    logic [7:0]            compare_reg;
    logic [7:0]            tick_count_reg,     tick_count_next;
    logic [7:0]            active_period_reg,  active_period_next;
    logic [7:0]            pending_period_reg, pending_period_next;
    logic [4:0]            last_note_reg,      last_note_next;
    logic [2:0]            volume_reg,         volume_next;
    logic [WAVE_IDX_W-1:0] wave_index_reg,     wave_index_next;
    logic                  out_valid_reg,      out_valid_next;
    logic [1:0]            out_kind_reg,       out_kind_next;
    logic [11:0]           out_value_reg,      out_value_next;

    bands_t                bands;
    logic                  take;
    logic                  nonzero;
    logic [WAVE_IDX_W+6:0] pos_wide;
    logic [SINE_POS_W-1:0] pos;
    logic [14:0]           scaled;
    logic [29:0]           recip;
    logic [11:0]           sample;

    pntg_bands u_bands
    (
        .reading (item.reading),
        .bands   (bands)
    );

    assign advance = !out_valid_reg || out_ready;
    assign take    = item_valid && advance;
    assign nonzero = item.reading != 16'd0;

    assign pos_wide = ({7'd0, wave_index_reg} * (WAVE_IDX_W + 7)'(64))
                      / (WAVE_IDX_W + 7)'(WAVE_POINTS);
    assign pos      = pos_wide[SINE_POS_W-1:0];
    assign scaled   = sine_value(pos) * {12'd0, volume_reg};
    // divide by 7 through a reciprocal, exact for products below 28672
    assign recip    = {15'd0, scaled} * 30'd18725;
    assign sample   = recip[28:17];

    always_comb
    begin
        tick_count_next     = tick_count_reg;
        active_period_next  = active_period_reg;
        pending_period_next = pending_period_reg;
        last_note_next      = last_note_reg;
        volume_next         = volume_reg;
        wave_index_next     = wave_index_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        out_kind_next       = out_kind_reg;
        out_value_next      = out_value_reg;

        if (take)
        begin
            out_valid_next = 1'b0;
            case (item.mode)
                MODE_TICK:
                begin
                    if ((tick_count_reg == compare_reg) && item.play_enable)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_SAMPLE;
                        out_value_next = sample;
                        if (wave_index_reg == WAVE_IDX_W'(WAVE_POINTS - 1))
                        begin
                            wave_index_next = '0;
                        end
                        else
                        begin
                            wave_index_next = wave_index_reg + 1'b1;
                        end
                    end
                    if (tick_count_reg >= active_period_reg)
                    begin
                        tick_count_next    = 8'd0;
                        active_period_next = pending_period_reg;
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg + 8'd1;
                    end
                end
                MODE_PITCH:
                begin
                    if (nonzero)
                    begin
                        pending_period_next = bands.period;
                        if (bands.note != last_note_reg)
                        begin
                            last_note_next = bands.note;
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_NOTE;
                            out_value_next = {7'd0, bands.note};
                        end
                    end
                end
                MODE_VOLUME:
                begin
                    if (nonzero && (bands.volume != volume_reg))
                    begin
                        volume_next    = bands.volume;
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_VOLUME;
                        out_value_next = {9'd0, bands.volume};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg        <= CMP_RESET;
            tick_count_reg     <= 8'd0;
            active_period_reg  <= PERIOD_RESET;
            pending_period_reg <= PERIOD_RESET;
            last_note_reg      <= 5'd0;
            volume_reg         <= 3'd0;
            wave_index_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                compare_reg <= cfg_data;
            end
            tick_count_reg     <= tick_count_next;
            active_period_reg  <= active_period_next;
            pending_period_reg <= pending_period_next;
            last_note_reg      <= last_note_next;
            volume_reg         <= volume_next;
            wave_index_reg     <= wave_index_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_value = out_value_reg;

endmodule

// ----- hw/rtl/proximity_note_tone_generator_top.sv -----
// An input beat is held in the input register, its result beat in the result register.
// Throughput: one input beat per cycle; the input register and the result register
// advance together, so the rate is set only by m_tready while a result beat is held.
// Reset (rst_n low, asynchronous): compare point 35, periods 141, count, note,
// volume and wave index 0; both stages empty.
module proximity_note_tone_generator_top
    import pntg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] reading, [16] play_enable, [23:17] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] value, [15:12] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);

    logic        in_valid_reg, in_valid_next;
    item_t       in_item_reg;
    logic        advance;
    logic [11:0] out_value;

    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // load on every accepted beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.mode        <= s_tuser;
            in_item_reg.reading     <= s_tdata[15:0];
            in_item_reg.play_enable <= s_tdata[16];
        end
    end

    pntg_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .out_ready  (m_tready),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_kind   (m_tuser),
        .out_value  (out_value)
    );

    assign m_tdata = {4'd0, out_value};

endmodule

// ----- hw/rtl/pntg_checker.sv -----
module pntg_checker
    import pntg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed under stall");

    a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_NOTE) |-> m_tdata <= {11'd0, NOTE_MAX})
        else $error("note index out of range");

    a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_VOLUME) |-> m_tdata <= {13'd0, VOL_MAX})
        else $error("volume scale out of range");

    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while result side is ready");

endmodule

bind proximity_note_tone_generator_top pntg_checker u_pntg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- bench/proximity_note_tone_generator_top_test.sv -----
module proximity_note_tone_generator_top_test;
    import pntg_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 6;

    typedef struct {
        kind_t       kind;
        logic [11:0] value;
    } tone_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;   // [15:0] reading, [16] play_enable, [23:17] zero
    logic [1:0]  s_tuser = 2'd0;    // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [11:0] value, [15:12] zero
    logic [1:0]  m_tuser;           // [1:0] kind

    item_t        pending_items[$];
    tone_result_t expected_beats[$];
    int unsigned  mismatch_count = 0;
    int unsigned  send_wait = 0;
    int unsigned  recv_wait = 0;
    bit           steady = 1'b0;

    logic [7:0]            cmp_pt;
    logic [7:0]            tick_cnt;
    logic [7:0]            period_now;
    logic [7:0]            period_next;
    logic [4:0]            note_now;
    logic [2:0]            vol_now;
    logic [WAVE_IDX_W-1:0] wave_pos;

    logic [11:0] wave_rom [0:63] = '{
        12'd2048, 12'd2249, 12'd2447, 12'd2642, 12'd2831, 12'd3013, 12'd3185, 12'd3347,
        12'd3495, 12'd3630, 12'd3750, 12'd3853, 12'd3939, 12'd4007, 12'd4056, 12'd4085,
        12'd4095, 12'd4085, 12'd4056, 12'd4007, 12'd3939, 12'd3853, 12'd3750, 12'd3630,
        12'd3495, 12'd3347, 12'd3185, 12'd3013, 12'd2831, 12'd2642, 12'd2447, 12'd2249,
        12'd2048, 12'd1847, 12'd1649, 12'd1454, 12'd1265, 12'd1083, 12'd911,  12'd749,
        12'd601,  12'd466,  12'd346,  12'd243,  12'd157,  12'd89,   12'd40,   12'd11,
        12'd1,    12'd11,   12'd40,   12'd89,   12'd157,  12'd243,  12'd346,  12'd466,
        12'd601,  12'd749,  12'd911,  12'd1083, 12'd1265, 12'd1454, 12'd1649, 12'd1847
    };

    logic [7:0] band_period [0:24] = '{
        8'd239, 8'd225, 8'd213, 8'd201, 8'd190, 8'd179, 8'd169, 8'd159, 8'd150,
        8'd142, 8'd134, 8'd126, 8'd119, 8'd113, 8'd106, 8'd100, 8'd95, 8'd89,
        8'd84, 8'd80, 8'd75, 8'd71, 8'd67, 8'd63, 8'd60
    };

    proximity_note_tone_generator_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic item_t make_item(input logic [1:0] mode, input int unsigned reading,
                                        input bit play);
        item_t it;
        it.mode = mode;
        it.reading = reading[15:0];
        it.play_enable = play;
        return it;
    endfunction

    function automatic int unsigned draw_wait();
        if (steady || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic int unsigned draw_reading(input int unsigned span);
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 0;
        if (k < 3)
            return $urandom_range(0, 65535);
        return $urandom_range(1, span);
    endfunction

    function automatic item_t random_item();
        int unsigned k;
        bit play;
        k = $urandom_range(0, 99);
        play = ($urandom_range(0, 7) != 0);
        if (k < 82)
            return make_item(MODE_TICK, $urandom_range(0, 65535), play);
        if (k < 90)
            return make_item(MODE_PITCH, draw_reading(700), play);
        if (k < 97)
            return make_item(MODE_VOLUME, draw_reading(500), play);
        return make_item(MODE_UNUSED, $urandom_range(0, 65535), play);
    endfunction

    task automatic predict_tone(input item_t it);
        int unsigned r;
        int unsigned n;
        int unsigned pos;
        int unsigned smp;
        tone_result_t res;
        r = it.reading;
        case (it.mode)
            MODE_TICK:
            begin
                if (tick_cnt == cmp_pt && it.play_enable)
                begin
                    pos = wave_pos;
                    pos = (pos * 64 / WAVE_POINTS) % 64;
                    smp = int'(wave_rom[pos]) * int'(vol_now) / 7;
                    res.kind = KIND_SAMPLE;
                    res.value = smp[11:0];
                    expected_beats.push_back(res);
                    if (wave_pos == WAVE_IDX_W'(WAVE_POINTS - 1))
                        wave_pos = '0;
                    else
                        wave_pos = wave_pos + 1'b1;
                end
                if (tick_cnt >= period_now)
                begin
                    tick_cnt = 8'd0;
                    period_now = period_next;
                end
                else
                begin
                    tick_cnt = tick_cnt + 8'd1;
                end
            end
            MODE_PITCH:
            begin
                if (r != 0)
                begin
                    n = (r < 75) ? 0 : (r - 75) / 25 + 1;
                    if (n > 24)
                        n = 24;
                    period_next = band_period[n];
                    if (n != note_now)
                    begin
                        note_now = n[4:0];
                        res.kind = KIND_NOTE;
                        res.value = 12'(n);
                        expected_beats.push_back(res);
                    end
                end
            end
            MODE_VOLUME:
            begin
                if (r != 0)
                begin
                    if (r < 75 || r >= 450)
                        n = 0;
                    else if (r >= 225)
                        n = 7;
                    else
                        n = (r - 75) / 25 + 1;
                    if (n != vol_now)
                    begin
                        vol_now = n[2:0];
                        res.kind = KIND_VOLUME;
                        res.value = 12'(n);
                        expected_beats.push_back(res);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 24'd0;
            s_tuser <= 2'd0;
            send_wait <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_wait != 0)
            begin
                send_wait <= send_wait - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, it.play_enable, it.reading};
                s_tuser <= it.mode;
                send_wait <= draw_wait();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_proc
        item_t it;
        tone_result_t want;
        int unsigned w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                it.mode = s_tuser;
                it.reading = s_tdata[15:0];
                it.play_enable = s_tdata[16];
                predict_tone(it);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected beat: kind %0d value %0d", m_tuser, m_tdata[11:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[11:0] !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, m_tdata[11:0]);
                        mismatch_count++;
                    end
                end
                w = draw_wait();
                recv_wait <= w;
                m_tready <= (w == 0);
            end
            else if (recv_wait != 0)
            begin
                recv_wait <= recv_wait - 1;
                m_tready <= (recv_wait == 1);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_compare(input logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        cmp_pt = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input logic [7:0] cmp, input int unsigned count, input bit calm);
        write_compare(cmp);
        steady = calm;
        repeat (count) pending_items.push_back(random_item());
        drain();
        steady = 1'b0;
    endtask

    initial
    begin
        cmp_pt = CMP_RESET;
        tick_cnt = 8'd0;
        period_now = PERIOD_RESET;
        period_next = PERIOD_RESET;
        note_now = 5'd0;
        vol_now = 3'd0;
        wave_pos = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // pitch band edges, repeated note, high clamp, zero reading
        pending_items.push_back(make_item(MODE_PITCH, 74, 1'b0));
        pending_items.push_back(make_item(MODE_PITCH, 75, 1'b1));
        pending_items.push_back(make_item(MODE_PITCH, 349, 1'b0));
        pending_items.push_back(make_item(MODE_PITCH, 350, 1'b1));
        pending_items.push_back(make_item(MODE_PITCH, 374, 1'b0));
        pending_items.push_back(make_item(MODE_PITCH, 375, 1'b1));
        pending_items.push_back(make_item(MODE_PITCH, 649, 1'b0));
        pending_items.push_back(make_item(MODE_PITCH, 650, 1'b1));
        pending_items.push_back(make_item(MODE_PITCH, 65535, 1'b1));
        pending_items.push_back(make_item(MODE_PITCH, 0, 1'b0));
        pending_items.push_back(make_item(MODE_UNUSED, 65535, 1'b1));
        // volume band edges, off from 450 up, zero reading
        pending_items.push_back(make_item(MODE_VOLUME, 74, 1'b0));
        pending_items.push_back(make_item(MODE_VOLUME, 75, 1'b1));
        pending_items.push_back(make_item(MODE_VOLUME, 224, 1'b0));
        pending_items.push_back(make_item(MODE_VOLUME, 225, 1'b1));
        pending_items.push_back(make_item(MODE_VOLUME, 449, 1'b0));
        pending_items.push_back(make_item(MODE_VOLUME, 450, 1'b1));
        pending_items.push_back(make_item(MODE_VOLUME, 0, 1'b0));
        pending_items.push_back(make_item(MODE_VOLUME, 65535, 1'b1));
        pending_items.push_back(make_item(MODE_VOLUME, 300, 1'b1));
        drain();

        // sample at count zero, then play off, then full-scale tick data
        write_compare(8'd0);
        pending_items.push_back(make_item(MODE_TICK, 0, 1'b1));
        pending_items.push_back(make_item(MODE_TICK, 0, 1'b0));
        pending_items.push_back(make_item(MODE_TICK, 65535, 1'b1));
        drain();

        run_random(8'd0, 190, 1'b0);
        run_random(8'd255, 190, 1'b0);
        run_random(8'd60, 190, 1'b1);
        run_random(8'd239, 190, 1'b0);
        run_random(8'($urandom_range(0, 255)), 190, 1'b0);
        run_random(CMP_RESET, 190, 1'b0);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
